FILE: rtl/csvs_pkg.sv
package csvs_pkg;

    localparam int CELL_TOTAL_W = 16;

    localparam logic [7:0]  ZERO_CHAR = 8'd48;
    localparam logic [7:0]  NINE_CHAR = 8'd57;

    localparam logic [31:0] SEPARATOR_RESET = 32'd44;
    localparam logic [31:0] ESCAPE_RESET    = 32'd0;

    // register index, taken from paddr[2]
    localparam logic REG_SEPARATOR = 1'b0;
    localparam logic REG_ESCAPE    = 1'b1;

    // one request from front to back: a first group of items (char bytes or
    // one cell-close item), an optional trailing '0' cell, an optional summary
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  n_first;
        logic        first_bv;
        logic        first_end;
        logic        trail;
        logic        summary;
    } t_cmd;

    // UTF-8 length from the lead byte; invalid leads count as one byte
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

endpackage

FILE: rtl/csv_row_field_splitter_unit.sv
// Path: a byte accepted on the byte side is registered in the request queue, then in the
//   back output register; later results of that byte follow one per cycle unless held by a low pop.
// Throughput: one byte per cycle while the queue is not full and each byte gives at most
//   one result; the back part issues one result per cycle unless a low pop holds it.
// Reset (synchronous, active low): clears row state, the request queue and the output
//   valid flag, sets the separator to ',' and the escape to none. No clearing pass is needed.
module csv_row_field_splitter_unit #(
    parameter int COUNT_WIDTH = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_row_last,
    // result side
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_cell_end,
    output logic        o_row_done,
    output logic [csvs_pkg::CELL_TOTAL_W-1:0] o_cell_total,
    output logic        o_header_flag,
    output logic        o_run_last,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration registers: separator at 0x0, escape at 0x4. The user writes them only
    // while the block is idle, so the front reads them directly; the block does not enforce it.
    // ------------------------------------------------------------------
    logic [31:0] r_separator_code;
    logic [31:0] r_escape_code;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == csvs_pkg::REG_ESCAPE) ? r_escape_code : r_separator_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator_code <= csvs_pkg::SEPARATOR_RESET;
            r_escape_code    <= csvs_pkg::ESCAPE_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == csvs_pkg::REG_SEPARATOR) begin
                r_separator_code <= pwdata;
            end else begin
                r_escape_code <= pwdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // Front: assembles UTF-8 characters, tracks escape and cell state,
    // keeps the row counters and turns each byte into at most one request.
    // Bytes that finish nothing (middle of a character) give no request unless they end the row.
    // ------------------------------------------------------------------
    logic                 accept;
    logic                 fe_wr;
    csvs_pkg::t_cmd       fe_cmd;
    logic [COUNT_WIDTH-1:0] fe_digits;
    logic [COUNT_WIDTH-1:0] fe_bytes;
    logic [COUNT_WIDTH-1:0] fe_cells;

    assign accept = push && !full;

    csvs_front #(
        .CW (COUNT_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_in_byte        (i_in_byte),
        .i_row_last       (i_row_last),
        .i_separator_code (r_separator_code),
        .i_escape_code    (r_escape_code),
        .o_wr             (fe_wr),
        .o_cmd            (fe_cmd),
        .o_digits         (fe_digits),
        .o_bytes          (fe_bytes),
        .o_cells          (fe_cells)
    );

    // ------------------------------------------------------------------
    // Request queue between front and back. When it fills, the byte side
    // stalls; the front never drops a request.
    // ------------------------------------------------------------------
    logic                 q_rd;
    logic                 q_empty;
    csvs_pkg::t_cmd       q_cmd;
    logic [COUNT_WIDTH-1:0] q_digits;
    logic [COUNT_WIDTH-1:0] q_bytes;
    logic [COUNT_WIDTH-1:0] q_cells;

    csvs_cmd_queue #(
        .CW    (COUNT_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (fe_wr),
        .i_cmd    (fe_cmd),
        .i_digits (fe_digits),
        .i_bytes  (fe_bytes),
        .i_cells  (fe_cells),
        .i_rd     (q_rd),
        .o_full   (full),
        .o_empty  (q_empty),
        .o_cmd    (q_cmd),
        .o_digits (q_digits),
        .o_bytes  (q_bytes),
        .o_cells  (q_cells)
    );

    // ------------------------------------------------------------------
    // Back: walks each request item by item (cell bytes or a close, then
    // an optional trailing '0' cell, then the row summary) into an output
    // register that holds while pop is low. The header flag is set when
    // 10*d <= n, a test run here as a shift-add and compare.
    // ------------------------------------------------------------------
    csvs_back #(
        .CW (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_cmd         (q_cmd),
        .i_digits      (q_digits),
        .i_bytes       (q_bytes),
        .i_cells       (q_cells),
        .o_q_rd        (q_rd),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_cell_end    (o_cell_end),
        .o_row_done    (o_row_done),
        .o_cell_total  (o_cell_total),
        .o_header_flag (o_header_flag),
        .o_run_last    (o_run_last)
    );

endmodule

FILE: rtl/csvs_front.sv
module csvs_front #(
    parameter int CW = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_in_byte,
    input  logic              i_row_last,
    input  logic [31:0]       i_separator_code,
    input  logic [31:0]       i_escape_code,
    output logic              o_wr,
    output csvs_pkg::t_cmd    o_cmd,
    output logic [CW-1:0]     o_digits,
    output logic [CW-1:0]     o_bytes,
    output logic [CW-1:0]     o_cells
);

    logic [31:0]   r_char_bytes;
    logic [2:0]    r_char_got;
    logic [2:0]    r_char_need;
    logic          r_escaped;
    logic          r_has_data;
    logic [CW-1:0] r_digits;
    logic [CW-1:0] r_bytes;
    logic [CW-1:0] r_cells;

    logic [2:0]    need;
    logic [31:0]   cb_new;
    logic [2:0]    got_new;
    logic          complete;
    logic          esc_new;
    logic          sep_hit;
    logic          data_hit;
    logic          has_after;
    logic          close_end;
    logic          trail;
    logic [1:0]    cell_inc;
    logic [CW:0]   cells_sum;
    logic [CW-1:0] n_digits;
    logic [CW-1:0] n_bytes;
    logic [CW-1:0] n_cells;
    logic          is_digit;
    csvs_pkg::t_cmd cmd;

    always_comb begin
        need     = (r_char_got == 3'd0) ? csvs_pkg::lead_len(i_in_byte) : r_char_need;
        unique case (r_char_got[1:0])
            2'd0: cb_new = r_char_bytes | {24'b0, i_in_byte};
            2'd1: cb_new = r_char_bytes | {16'b0, i_in_byte, 8'b0};
            2'd2: cb_new = r_char_bytes | {8'b0, i_in_byte, 16'b0};
            default: cb_new = r_char_bytes | {i_in_byte, 24'b0};
        endcase
        got_new  = r_char_got + 3'd1;
        complete = (got_new >= need);

        esc_new  = r_escaped ^ (complete && (i_escape_code != 32'd0)
                                && (cb_new == i_escape_code));
        sep_hit  = complete && (i_separator_code != 32'd0)
                   && (cb_new == i_separator_code) && !esc_new;
        data_hit = complete && !sep_hit;
        has_after = sep_hit ? 1'b0 : (data_hit ? 1'b1 : r_has_data);

        // row end with open cell and no character completed by this byte
        close_end = i_row_last && r_has_data && !complete;
        trail     = i_row_last && (csvs_pkg::lead_len(i_in_byte) == 3'd1)
                    && (i_separator_code != 32'd0)
                    && (i_separator_code == {24'b0, i_in_byte}) && !esc_new;

        cell_inc  = 2'(sep_hit) + 2'(i_row_last && has_after) + 2'(trail);
        cells_sum = {1'b0, r_cells} + (CW+1)'(cell_inc);
        n_cells   = cells_sum[CW] ? '1 : cells_sum[CW-1:0];

        is_digit  = (i_in_byte >= csvs_pkg::ZERO_CHAR) && (i_in_byte <= csvs_pkg::NINE_CHAR);
        n_bytes   = (r_bytes == '1) ? r_bytes : r_bytes + 1'b1;
        n_digits  = (is_digit && (r_digits != '1)) ? r_digits + 1'b1 : r_digits;

        cmd = '0;
        if (sep_hit) begin
            cmd.n_first   = 3'd1;
            cmd.bytes     = r_has_data ? 32'd0 : {24'b0, csvs_pkg::ZERO_CHAR};
            cmd.first_bv  = !r_has_data;
            cmd.first_end = 1'b1;
        end else if (data_hit) begin
            cmd.n_first   = got_new;
            cmd.bytes     = cb_new;
            cmd.first_bv  = 1'b1;
            cmd.first_end = i_row_last;
        end else if (close_end) begin
            cmd.n_first   = 3'd1;
            cmd.first_end = 1'b1;
        end
        cmd.trail   = trail;
        cmd.summary = i_row_last;
    end

    assign o_wr     = i_accept && ((cmd.n_first != 3'd0) || i_row_last);
    assign o_cmd    = cmd;
    assign o_digits = n_digits;
    assign o_bytes  = n_bytes;
    assign o_cells  = n_cells;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_row_last)) begin
            r_char_bytes <= '0;
            r_char_got   <= '0;
            r_char_need  <= '0;
            r_escaped    <= 1'b0;
            r_has_data   <= 1'b0;
            r_digits     <= '0;
            r_bytes      <= '0;
            r_cells      <= '0;
        end else if (i_accept) begin
            if (complete) begin
                r_char_bytes <= '0;
                r_char_got   <= '0;
                r_char_need  <= '0;
            end else begin
                r_char_bytes <= cb_new;
                r_char_got   <= got_new;
                r_char_need  <= need;
            end
            r_escaped  <= esc_new;
            r_has_data <= has_after;
            r_digits   <= n_digits;
            r_bytes    <= n_bytes;
            r_cells    <= n_cells;
        end
    end

endmodule

FILE: rtl/csvs_cmd_queue.sv
module csvs_cmd_queue #(
    parameter int CW    = 16,
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  csvs_pkg::t_cmd    i_cmd,
    input  logic [CW-1:0]     i_digits,
    input  logic [CW-1:0]     i_bytes,
    input  logic [CW-1:0]     i_cells,
    input  logic              i_rd,
    output logic              o_full,
    output logic              o_empty,
    output csvs_pkg::t_cmd    o_cmd,
    output logic [CW-1:0]     o_digits,
    output logic [CW-1:0]     o_bytes,
    output logic [CW-1:0]     o_cells
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

    csvs_pkg::t_cmd r_cmd    [DEPTH];
    logic [CW-1:0]  r_digits [DEPTH];
    logic [CW-1:0]  r_bytes  [DEPTH];
    logic [CW-1:0]  r_cells  [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [NW-1:0]  r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;

    assign o_cmd    = r_cmd[r_rd_ptr];
    assign o_digits = r_digits[r_rd_ptr];
    assign o_bytes  = r_bytes[r_rd_ptr];
    assign o_cells  = r_cells[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_cmd[r_wr_ptr]    <= i_cmd;
            r_digits[r_wr_ptr] <= i_digits;
            r_bytes[r_wr_ptr]  <= i_bytes;
            r_cells[r_wr_ptr]  <= i_cells;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/csvs_back.sv
module csvs_back #(
    parameter int CW = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  csvs_pkg::t_cmd    i_cmd,
    input  logic [CW-1:0]     i_digits,
    input  logic [CW-1:0]     i_bytes,
    input  logic [CW-1:0]     i_cells,
    output logic              o_q_rd,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_out_byte,
    output logic              o_byte_valid,
    output logic              o_cell_end,
    output logic              o_row_done,
    output logic [csvs_pkg::CELL_TOTAL_W-1:0] o_cell_total,
    output logic              o_header_flag,
    output logic              o_run_last
);

    localparam int TW = csvs_pkg::CELL_TOTAL_W;

    logic [2:0]      r_idx;
    logic            r_valid;
    logic [7:0]      r_out_byte;
    logic            r_byte_valid;
    logic            r_cell_end;
    logic            r_row_done;
    logic [TW-1:0]   r_cell_total;
    logic            r_header_flag;
    logic            r_run_last;

    logic [2:0]      total;
    logic            in_first;
    logic            is_trail;
    logic            last_item;
    logic            advance;
    logic [CW+3:0]   digits_x10;
    logic [CW+TW-1:0] cells_ext;
    logic [7:0]      n_out_byte;
    logic            n_byte_valid;
    logic            n_cell_end;
    logic            n_row_done;
    logic [TW-1:0]   n_cell_total;
    logic            n_header_flag;

    always_comb begin
        total     = i_cmd.n_first + 3'(i_cmd.trail) + 3'(i_cmd.summary);
        in_first  = (r_idx < i_cmd.n_first);
        is_trail  = !in_first && i_cmd.trail && (r_idx == i_cmd.n_first);
        last_item = (r_idx == total - 3'd1);
        advance   = !i_q_empty && (!r_valid || i_pop);

        // 10*d as 8*d + 2*d
        digits_x10 = {1'b0, i_digits, 3'b0} + {3'b0, i_digits, 1'b0};
        cells_ext  = {{TW{1'b0}}, i_cells};

        n_out_byte    = 8'd0;
        n_byte_valid  = 1'b0;
        n_cell_end    = 1'b0;
        n_row_done    = 1'b0;
        n_cell_total  = '0;
        n_header_flag = 1'b0;
        if (in_first) begin
            n_out_byte   = i_cmd.bytes[8*r_idx[1:0] +: 8];
            n_byte_valid = i_cmd.first_bv;
            n_cell_end   = i_cmd.first_end && (r_idx == i_cmd.n_first - 3'd1);
        end else if (is_trail) begin
            n_out_byte   = csvs_pkg::ZERO_CHAR;
            n_byte_valid = 1'b1;
            n_cell_end   = 1'b1;
        end else begin
            n_row_done    = 1'b1;
            n_cell_total  = (cells_ext > (CW+TW)'({TW{1'b1}})) ? '1 : cells_ext[TW-1:0];
            n_header_flag = !(digits_x10 > (CW+4)'(i_bytes));
        end
    end

    assign o_q_rd = advance && last_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx   <= last_item ? 3'd0 : r_idx + 3'd1;
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte    <= n_out_byte;
            r_byte_valid  <= n_byte_valid;
            r_cell_end    <= n_cell_end;
            r_row_done    <= n_row_done;
            r_cell_total  <= n_cell_total;
            r_header_flag <= n_header_flag;
            r_run_last    <= last_item;
        end
    end

    assign o_empty       = !r_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_valid  = r_byte_valid;
    assign o_cell_end    = r_cell_end;
    assign o_row_done    = r_row_done;
    assign o_cell_total  = r_cell_total;
    assign o_header_flag = r_header_flag;
    assign o_run_last    = r_run_last;

endmodule
